/* hdl/ida_pkg.sv */
// Package for the integer to decimal ASCII converter.
// Holds character codes, BCD constants, the sequencer state type and the control struct.
// No dependencies.
package ida_pkg;

  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;

  // Double dabble digit correction: add three to a digit of five or more.
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_SIGN,
    ST_EMIT
  } ida_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic drop_digit;
    logic in_ready;
    logic out_valid;
    logic out_sign;
    logic out_last;
  } ida_ctrl_t;

endpackage

/* hdl/ida_if.sv */
// Valid/ready channel interfaces of the integer to decimal ASCII converter.
// Depends on ida_pkg for the character width.
interface ida_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface ida_out_if;
  import ida_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

/* hdl/integer_to_decimal_ascii.sv */
// Top level of the signed integer to decimal ASCII converter.
// Depends on ida_pkg, ida_if, ida_bcd_unit and ida_ctrl.
//
// Takes one signed VALUE_WIDTH-bit word and sends its decimal text as one
// ASCII character per output word, most significant first: '-' ahead of a
// negative value, no leading zeros, a single '0' for zero, last set on the
// final character. The most negative value prints in full because its
// magnitude is kept unsigned. Each word is loaded, then passes through
// VALUE_WIDTH double dabble steps in the shared BCD correct-and-shift
// unit, then the trim drops leading zeros, then the characters go out one
// per cycle while the sink is ready; a sink that is not ready stalls them.
// Dropped zeros and digits together always number NUM_DIGITS, and a minus
// sign adds one character to the text.
// The input is ready only while the block is idle; NUM_DIGITS is
// (3 * VALUE_WIDTH) / 10 + 1 BCD digits, enough for 2^(VALUE_WIDTH-1).
module integer_to_decimal_ascii import ida_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ida_in_if.sink    in_ch,
  ida_out_if.source out_ch
);

  localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int BCD_W = NUM_DIGITS * DIGIT_W;

  ida_ctrl_t ctl;

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic                   neg_r, neg_nxt;
  logic [BCD_W-1:0]       bcd_step;
  logic [DIGIT_W-1:0]     top_digit;
  logic [VALUE_WIDTH-1:0] raw;

  assign raw       = in_ch.value;
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

  ida_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .neg       (neg_r),
    .top_zero  (top_digit == '0),
    .ctl       (ctl)
  );

  // Shared conversion unit: one magnitude bit enters the BCD register per step.
  ida_bcd_unit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_bcd (
    .bcd_in  (bcd_r),
    .bit_in  (mag_r[VALUE_WIDTH-1]),
    .bcd_out (bcd_step)
  );

  // Datapath: load the magnitude, advance the conversion, drop digits from the top.
  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    priority if (ctl.load) begin
      neg_nxt = raw[VALUE_WIDTH-1];
      mag_nxt = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
      bcd_nxt = '0;
    end else if (ctl.step) begin
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_nxt = bcd_step;
    end else if (ctl.drop_digit) begin
      bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign in_ch.ready      = ctl.in_ready;
  assign out_ch.valid     = ctl.out_valid;
  assign out_ch.last      = ctl.out_last;
  assign out_ch.character = ctl.out_sign ? CHAR_MINUS
                                         : (CHAR_ZERO + CHAR_W'(top_digit));

  // Every emitted word is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.character == CHAR_MINUS ||
                      (out_ch.character >= CHAR_ZERO && out_ch.character <= CHAR_NINE)))
    else $error("output character out of range");

  // The block never takes a new word while text is being sent.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while output valid");

  // After an input word is taken, the input stays closed for the conversion.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (!in_ch.ready && !out_ch.valid))
    else $error("block not busy after accept");

  // The sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.character == CHAR_MINUS) |-> !out_ch.last)
    else $error("minus sign flagged last");

endmodule

/* hdl/ida_bcd_unit.sv */
// One double dabble step: correct each BCD digit, then shift in one binary bit.
// Depends on ida_pkg.
module ida_bcd_unit import ida_pkg::*; #(
  parameter int NUM_DIGITS = 10
) (
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_in,
  input  logic                          bit_in,
  output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_out
);

  logic [NUM_DIGITS*DIGIT_W-1:0] adj;

  for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_digit
    logic [DIGIT_W-1:0] dig;
    assign dig = bcd_in[d*DIGIT_W +: DIGIT_W];
    assign adj[d*DIGIT_W +: DIGIT_W] = (dig >= BCD_ADJ_MIN) ? (dig + BCD_ADJ) : dig;
  end

  assign bcd_out = {adj[NUM_DIGITS*DIGIT_W-2:0], bit_in};

endmodule

/* hdl/ida_ctrl.sv */
// Sequencer of the converter: load, conversion steps, leading-zero trim, minus sign, emit.
// Depends on ida_pkg.
module ida_ctrl import ida_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int NUM_DIGITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  logic      neg,
  input  logic      top_zero,
  output ida_ctrl_t ctl
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  ida_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CONV;
      ST_CONV: if (cnt_r == CW'(1)) state_nxt = ST_TRIM;
      ST_TRIM: begin
        if (!(top_zero && cnt_r > CW'(1))) state_nxt = neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: if (out_ready) state_nxt = ST_EMIT;
      ST_EMIT: if (out_ready && cnt_r == CW'(1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.load     = in_valid;
      end
      ST_CONV: ctl.step = 1'b1;
      ST_TRIM: ctl.drop_digit = top_zero && cnt_r > CW'(1);
      ST_SIGN: begin
        ctl.out_valid = 1'b1;
        ctl.out_sign  = 1'b1;
      end
      ST_EMIT: begin
        ctl.out_valid  = 1'b1;
        ctl.out_last   = cnt_r == CW'(1);
        ctl.drop_digit = out_ready;
      end
      default: ctl = '0;
    endcase
  end

  // step and digit counter
  always_comb begin
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) cnt_nxt = CW'(VALUE_WIDTH);
      ST_CONV: cnt_nxt = (cnt_r == CW'(1)) ? CW'(NUM_DIGITS) : cnt_r - CW'(1);
      ST_TRIM: if (top_zero && cnt_r > CW'(1)) cnt_nxt = cnt_r - CW'(1);
      ST_SIGN: cnt_nxt = cnt_r;
      ST_EMIT: if (out_ready) cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

endmodule
